>>> hdl/tccg_pkg.sv
// Shared types and constants of the text console cell grid.
// Request and response payload structs, opcodes, character codes, control structs.
// No dependencies.
package tccg_pkg;

	// Opcodes of a request
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Character codes with special meaning
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// Blank colour after reset
	localparam logic [31:0] RESET_BLANK = 32'h00FF_FFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  char_code;
		logic [31:0] char_colour;
		logic [4:0]  read_row;
		logic [5:0]  read_col;
	} tccg_req_t;

	typedef struct packed {
		logic [7:0]  cell_char;
		logic [31:0] cell_colour;
		logic [4:0]  cursor_row;
		logic [5:0]  cursor_col;
	} tccg_rsp_t;

	// Write enables of the character and colour memories
	typedef struct packed {
		logic char_we;
		logic colour_we;
	} tccg_wr_en_t;

	// Response register control: load it, and take the cell from memory read data
	typedef struct packed {
		logic load;
		logic from_ram;
	} tccg_res_ctl_t;

endpackage

>>> hdl/text_console_cell_grid_top.sv
// Text console cell grid top level: handshakes, response register, cell memories.
// Depends on tccg_pkg, tccg_ram and tccg_ctrl.
//
// A put, newline, backspace, clear or unused-op request gets its response in the
// cycle after it is taken; a read passes through the registered read port of the
// cell memories and then the response register. Rows live in a ring inside the
// memories, so a scroll only blanks the new bottom row: req_stall stays high while
// that row is blanked after the request that scrolls. A clear blanks every cell,
// and after reset the same pass runs before the first request is taken. The blank
// colour register can be written at any time and applies to later clears and
// scrolls. A response waiting on rsp_stall holds off the next request only while
// the response register is full.
module text_console_cell_grid_top import tccg_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  tccg_req_t   req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output tccg_rsp_t   rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	logic          busy;
	logic          accept;
	logic [AW-1:0] raddr, waddr;
	logic [7:0]    wchar, rchar;
	logic [31:0]   wcolour, rcolour;
	tccg_wr_en_t   wr_en;
	tccg_rsp_t     res;
	tccg_res_ctl_t res_ctl;
	logic          rsp_valid_q;
	tccg_rsp_t     rsp_q;
	tccg_rsp_t     rsp_d;

	// Take a request only when idle and the response register can take its result
	assign req_stall = busy || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	tccg_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.raddr     (raddr),
		.waddr     (waddr),
		.wchar     (wchar),
		.wcolour   (wcolour),
		.wr_en     (wr_en),
		.res       (res),
		.res_ctl   (res_ctl)
	);

	tccg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_char_ram (
		.clk   (clk),
		.we    (wr_en.char_we),
		.waddr (waddr),
		.wdata (wchar),
		.raddr (raddr),
		.rdata (rchar)
	);

	tccg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_colour_ram (
		.clk   (clk),
		.we    (wr_en.colour_we),
		.waddr (waddr),
		.wdata (wcolour),
		.raddr (raddr),
		.rdata (rcolour)
	);

	// Response valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ctl.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Merge the cell read from memory on reads
	always_comb begin
		rsp_d = res;
		if (res_ctl.from_ram) begin
			rsp_d.cell_char   = rchar;
			rsp_d.cell_colour = rcolour;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (res_ctl.load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/tccg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tccg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/tccg_ctrl.sv
// Console control: cursor, row ring offset, blank sweeps and memory commands.
// Depends on tccg_pkg.
module tccg_ctrl import tccg_pkg::*; #(
	parameter int ROWS = 32,
	parameter int COLS = 64,
	localparam int RW = $clog2(ROWS),
	localparam int CW = $clog2(COLS),
	localparam int AW = RW + CW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  tccg_req_t     req,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	output logic          busy,
	output logic [AW-1:0] raddr,
	output logic [AW-1:0] waddr,
	output logic [7:0]    wchar,
	output logic [31:0]   wcolour,
	output tccg_wr_en_t   wr_en,
	output tccg_rsp_t     res,
	output tccg_res_ctl_t res_ctl
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RD    = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

	logic [1:0]    state_q;
	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [RW-1:0] top_q, top_d;
	logic [RW-1:0] sweep_row_q;
	logic [CW-1:0] sweep_col_q;
	logic          sweep_all_q;
	logic [31:0]   sweep_colour_q;
	logic [31:0]   blank_colour_q;
	logic          rd_ok_q;
	logic          do_scroll, do_clear, nl_evt;
	logic          is_nl, is_bs;
	logic [RW-1:0] cur_phys, rd_phys;
	logic          rd_ok;

	// Map a screen row onto its memory row through the ring offset
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
			input logic [RW-1:0] top);
		logic [RW:0] sum;
		sum = {1'b0, lrow} + {1'b0, top};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		return sum[RW-1:0];
	endfunction

	assign busy     = (state_q != ST_IDLE);
	assign is_nl    = (req.char_code == CH_LF) || (req.char_code == CH_CR);
	assign is_bs    = (req.char_code == CH_BS) || (req.char_code == CH_DEL);
	assign cur_phys = phys_row(cur_row_q, top_q);
	assign rd_phys  = phys_row(RW'(req.read_row), top_q);
	assign rd_ok    = ({3'b000, req.read_row} < 8'(ROWS)) && ({3'b000, req.read_col} < 9'(COLS));
	assign raddr    = {rd_phys, CW'(req.read_col)};

	// Next cursor and ring offset for an accepted request
	always_comb begin
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		top_d     = top_q;
		do_scroll = 1'b0;
		do_clear  = 1'b0;
		nl_evt    = 1'b0;
		if (accept) begin
			case (req.op)
				OP_PUT: begin
					if (is_nl) begin
						nl_evt = 1'b1;
					end else if (is_bs) begin
						if (cur_col_q != '0) begin
							cur_col_d = cur_col_q - 1'b1;
						end
					end else if (cur_col_q == COL_LAST) begin
						nl_evt = 1'b1;
					end else begin
						cur_col_d = cur_col_q + 1'b1;
					end
				end
				OP_CLEAR: begin
					cur_row_d = '0;
					cur_col_d = '0;
					top_d     = '0;
					do_clear  = 1'b1;
				end
				default: begin
				end
			endcase
			if (nl_evt) begin
				cur_col_d = '0;
				if (cur_row_q == ROW_LAST) begin
					do_scroll = 1'b1;
					top_d     = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;
				end else begin
					cur_row_d = cur_row_q + 1'b1;
				end
			end
		end
	end

	// Memory write command: blank sweep, or the cell touched by a put
	always_comb begin
		wr_en   = '0;
		waddr   = {cur_phys, cur_col_q};
		wchar   = req.char_code;
		wcolour = req.char_colour;
		if (state_q == ST_SWEEP) begin
			wr_en   = '{char_we: 1'b1, colour_we: 1'b1};
			waddr   = {sweep_row_q, sweep_col_q};
			wchar   = CH_SPACE;
			wcolour = sweep_colour_q;
		end else if (accept && req.op == OP_PUT && !is_nl) begin
			if (is_bs) begin
				waddr         = {cur_phys, cur_col_q - 1'b1};
				wchar         = CH_SPACE;
				wr_en.char_we = (cur_col_q != '0);
			end else begin
				wr_en = '{char_we: 1'b1, colour_we: 1'b1};
			end
		end
	end

	// Response: cursor after the request; cell fields filled from memory on in-range reads
	always_comb begin
		res             = '0;
		res_ctl         = '0;
		if (state_q == ST_RD) begin
			res.cursor_row   = 5'(cur_row_q);
			res.cursor_col   = 6'(cur_col_q);
			res_ctl.load     = 1'b1;
			res_ctl.from_ram = rd_ok_q;
		end else begin
			res.cursor_row = 5'(cur_row_d);
			res.cursor_col = 6'(cur_col_d);
			res_ctl.load   = accept && (req.op != OP_READ);
		end
	end

	// Blank colour register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_colour_q <= RESET_BLANK;
		end else if (cfg_we) begin
			blank_colour_q <= cfg_wdata;
		end
	end

	// Cursor, ring offset and read range flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			top_q     <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			top_q     <= top_d;
			if (accept) begin
				rd_ok_q <= rd_ok;
			end
		end
	end

	// Sequencer: idle, read wait, blank sweep (reset starts with a full sweep)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_SWEEP;
			sweep_row_q    <= '0;
			sweep_col_q    <= '0;
			sweep_all_q    <= 1'b1;
			sweep_colour_q <= RESET_BLANK;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_clear) begin
						state_q        <= ST_SWEEP;
						sweep_row_q    <= '0;
						sweep_col_q    <= '0;
						sweep_all_q    <= 1'b1;
						sweep_colour_q <= blank_colour_q;
					end else if (do_scroll) begin
						// old top row becomes the new bottom row
						state_q        <= ST_SWEEP;
						sweep_row_q    <= top_q;
						sweep_col_q    <= '0;
						sweep_all_q    <= 1'b0;
						sweep_colour_q <= blank_colour_q;
					end else if (accept && req.op == OP_READ) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (sweep_col_q == COL_LAST) begin
						sweep_col_q <= '0;
						if (!sweep_all_q || sweep_row_q == ROW_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							sweep_row_q <= sweep_row_q + 1'b1;
						end
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/tccg_chk.sv
// Port-level checker for the text console cell grid, bound to the top level.
// Depends on tccg_pkg and text_console_cell_grid_top.
module tccg_chk import tccg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input tccg_req_t   req,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input tccg_rsp_t   rsp
);

	logic req_acc;
	assign req_acc = req_valid && !req_stall;

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Non-read request answers next cycle with empty cell fields
	a_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.op != OP_READ |=>
			rsp_valid && rsp.cell_char == 8'd0 && rsp.cell_colour == 32'd0)
		else $error("non-read response missing or cell not zero");

	// Read request answers after blocking the request port while it waits
	a_read_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.op == OP_READ |=> req_stall ##1 rsp_valid)
		else $error("read response timing wrong");

	// Clear homes the cursor
	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.op == OP_CLEAR |=> rsp.cursor_row == 5'd0 && rsp.cursor_col == 6'd0)
		else $error("clear did not home cursor");

endmodule

bind text_console_cell_grid_top tccg_chk u_tccg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> tb/tb_top.sv
// Self-checking testbench of the text console cell grid: an in-bench console model
// predicts every response and a checker compares it field by field. Needs tccg_pkg.
// Covers put, newline, backspace, wrap, scroll, clear, read, the unused op and config.
module tb_top import tccg_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS  = 32;
	localparam int COLS  = 64;
	localparam int CELLS = ROWS * COLS;
	// Longest background pass of the block: a full clear
	localparam int SETTLE_CYCLES = ROWS * COLS + 64;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	tccg_req_t   req;
	logic        rsp_valid;
	logic        rsp_stall;
	tccg_rsp_t   rsp;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// Console model state
	logic [7:0]  cell_chars [CELLS];
	logic [31:0] cell_colours [CELLS];
	int unsigned cursor_r;
	int unsigned cursor_c;
	logic [31:0] blank_col;

	tccg_rsp_t   cell_reports [$];
	int          mismatches;
	int          sent_items;
	bit          quiet;

	text_console_cell_grid_top #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------- console model ----------------

	function automatic void blank_grid();
		for (int i = 0; i < CELLS; i++) begin
			cell_chars[i] = CH_SPACE;
			cell_colours[i] = blank_col;
		end
		cursor_r = 0;
		cursor_c = 0;
	endfunction

	// Shift rows up by one and blank the new bottom row
	function automatic void roll_up();
		for (int i = 0; i < CELLS - COLS; i++) begin
			cell_chars[i] = cell_chars[i + COLS];
			cell_colours[i] = cell_colours[i + COLS];
		end
		for (int i = CELLS - COLS; i < CELLS; i++) begin
			cell_chars[i] = CH_SPACE;
			cell_colours[i] = blank_col;
		end
		cursor_r = ROWS - 1;
	endfunction

	function automatic void line_feed();
		cursor_c = 0;
		cursor_r++;
		if (cursor_r >= ROWS) begin
			roll_up();
		end
	endfunction

	// Apply one request to the model and return the response it causes
	function automatic tccg_rsp_t console_update(tccg_req_t r);
		tccg_rsp_t o;
		int unsigned at;
		o = '0;
		case (r.op)
			OP_PUT: begin
				if (r.char_code == CH_LF || r.char_code == CH_CR) begin
					line_feed();
				end else if (r.char_code == CH_BS || r.char_code == CH_DEL) begin
					if (cursor_c > 0) begin
						cursor_c--;
						cell_chars[cursor_r * COLS + cursor_c] = CH_SPACE;
					end
				end else begin
					at = cursor_r * COLS + cursor_c;
					cell_chars[at] = r.char_code;
					cell_colours[at] = r.char_colour;
					cursor_c++;
					if (cursor_c >= COLS) begin
						line_feed();
					end
				end
			end
			OP_READ: begin
				if (r.read_row < ROWS && r.read_col < COLS) begin
					at = r.read_row * COLS + r.read_col;
					o.cell_char = cell_chars[at];
					o.cell_colour = cell_colours[at];
				end
			end
			OP_CLEAR: begin
				blank_grid();
			end
			default: begin
			end
		endcase
		o.cursor_row = cursor_r[4:0];
		o.cursor_col = cursor_c[5:0];
		return o;
	endfunction

	// ---------------- request side ----------------

	function automatic int pick_gap();
		if (quiet) begin
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic tccg_req_t random_item(logic [1:0] op);
		tccg_req_t r;
		r.op = op;
		r.char_code = 8'($urandom);
		r.char_colour = $urandom;
		r.read_row = 5'($urandom);
		r.read_col = 6'($urandom);
		return r;
	endfunction

	function automatic tccg_req_t put_item(logic [7:0] ch, logic [31:0] colour);
		tccg_req_t r;
		r = random_item(OP_PUT);
		r.char_code = ch;
		r.char_colour = colour;
		return r;
	endfunction

	function automatic tccg_req_t read_item(logic [4:0] row, logic [5:0] col);
		tccg_req_t r;
		r = random_item(OP_READ);
		r.read_row = row;
		r.read_col = col;
		return r;
	endfunction

	// Send one request; entered and left at a falling edge with valid still high
	task automatic send_req(tccg_req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			req <= random_item(2'($urandom));
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		cell_reports.push_back(console_update(item));
		sent_items++;
		@(negedge clk);
	endtask

	task automatic drop_req();
		req_valid <= 1'b0;
	endtask

	// Wait until every response is in and the background pass is done
	task automatic wait_idle();
		while (cell_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_blank(logic [31:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= $urandom;
		blank_col = value;
	endtask

	// ---------------- response side ----------------

	initial begin
		tccg_rsp_t want;
		int gap;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			if (cell_reports.size() == 0) begin
				$error("response with no request pending: %p", rsp);
				mismatches++;
			end else begin
				want = cell_reports.pop_front();
				if (rsp.cell_char !== want.cell_char) begin
					$error("cell_char expected %0h actual %0h", want.cell_char, rsp.cell_char);
					mismatches++;
				end
				if (rsp.cell_colour !== want.cell_colour) begin
					$error("cell_colour expected %0h actual %0h",
						want.cell_colour, rsp.cell_colour);
					mismatches++;
				end
				if (rsp.cursor_row !== want.cursor_row) begin
					$error("cursor_row expected %0d actual %0d",
						want.cursor_row, rsp.cursor_row);
					mismatches++;
				end
				if (rsp.cursor_col !== want.cursor_col) begin
					$error("cursor_col expected %0d actual %0d",
						want.cursor_col, rsp.cursor_col);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	// ---------------- tests ----------------

	// Read corners after reset, unused op, backspace at column zero
	task automatic test_reset_state();
		send_req(read_item(5'd0, 6'd0));
		send_req(read_item(5'd31, 6'd63));
		send_req(random_item(OP_NONE));
		send_req(put_item(CH_BS, $urandom));
		send_req(put_item(CH_DEL, $urandom));
		drop_req();
	endtask

	// Character extremes, erase, both newlines, clear
	task automatic test_directed();
		send_req(put_item(8'h00, 32'h0000_0000));
		send_req(put_item(8'hFF, 32'hFFFF_FFFF));
		send_req(read_item(5'd0, 6'd1));
		send_req(put_item(CH_DEL, $urandom));
		send_req(read_item(5'd0, 6'd1));
		send_req(put_item(CH_BS, $urandom));
		send_req(read_item(5'd0, 6'd0));
		send_req(put_item(8'h41, $urandom));
		send_req(put_item(CH_CR, $urandom));
		send_req(put_item(8'h42, $urandom));
		send_req(put_item(CH_LF, $urandom));
		send_req(read_item(5'd0, 6'd0));
		send_req(read_item(5'd1, 6'd0));
		send_req(random_item(OP_NONE));
		send_req(random_item(OP_CLEAR));
		send_req(read_item(5'd1, 6'd0));
		send_req(read_item(5'd31, 6'd63));
		drop_req();
	endtask

	// Fill past the last row so the grid scrolls, reading the bottom two rows after each line
	task automatic test_scroll_lines();
		int len;
		send_req(random_item(OP_CLEAR));
		for (int ln = 0; ln < 40; ln++) begin
			len = $urandom_range(0, 8);
			for (int k = 0; k < len; k++) begin
				send_req(put_item(8'($urandom_range(33, 126)), $urandom));
			end
			send_req(put_item(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR, $urandom));
			send_req(read_item(5'd31, 6'($urandom)));
			send_req(read_item(5'd30, 6'($urandom_range(0, 8))));
		end
		drop_req();
	endtask

	// Mostly lines of text with reads in between; some noise and rare clears
	task automatic test_random_mix(int count);
		int target;
		int pick;
		int len;
		logic [7:0] ch;
		target = sent_items + count;
		while (sent_items < target) begin
			if ($urandom_range(0, 29) == 0) begin
				quiet = !quiet;
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70)
					: $urandom_range(0, 12);
				for (int k = 0; k < len; k++) begin
					ch = 8'($urandom);
					// keep the text ordinary, erase now and then
					if (ch == CH_LF || ch == CH_CR || ch == CH_BS || ch == CH_DEL) begin
						ch = ch ^ 8'h40;
					end
					if ($urandom_range(0, 9) == 0) begin
						ch = ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
					end
					send_req(put_item(ch, $urandom));
				end
				send_req(put_item(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR, $urandom));
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1) != 0) begin
						send_req(read_item(5'(cursor_r), 6'($urandom)));
					end else begin
						send_req(read_item(5'($urandom), 6'($urandom)));
					end
				end
			end else if (pick < 98) begin
				send_req(random_item(($urandom_range(0, 1) != 0) ? OP_NONE : OP_PUT));
			end else begin
				send_req(random_item(OP_CLEAR));
			end
		end
		quiet = 1'b0;
		drop_req();
	endtask

	// ---------------- main sequence ----------------

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mismatches = 0;
		sent_items = 0;
		quiet = 1'b0;
		blank_col = RESET_BLANK;
		blank_grid();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed();
		write_blank(32'h0000_0000);
		test_scroll_lines();
		write_blank(32'hFFFF_FFFF);
		test_random_mix(150);
		write_blank($urandom);
		quiet = 1'b1;
		test_random_mix(100);
		write_blank(RESET_BLANK);
		test_random_mix(150);
		write_blank($urandom);
		test_random_mix(150);

		wait_idle();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/tccg_pkg.sv
hdl/tccg_ram.sv
hdl/tccg_ctrl.sv
hdl/text_console_cell_grid_top.sv
hdl/tccg_chk.sv
tb/tb_top.sv
